/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked at the same clock edge.
`define ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked at the next clock edge.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sebfr_pkg.sv */
// ----------------------------------------------------------------------------
// sebfr_pkg
// Types and constants of the STX/ETX frame receiver with XOR block check.
// ----------------------------------------------------------------------------
package sebfr_pkg;

   localparam int FRAME_MAX_DEF = 64;

   localparam int CNT_W  = 7;
   localparam int BYTE_W = 8;

   // Actions carried on the input item.
   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_BYTE   = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_UNUSED = 2'd3
   } action_type;

   // Completion status of a frame.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_LIMIT    = 2'd1,
      ST_CHKSUM   = 2'd2,
      ST_TIMEOUT  = 2'd3
   } status_type;

   // Register indexes of the configuration port.
   localparam logic REG_MAX_BYTES = 1'b0;

   localparam logic [CNT_W-1:0] MAX_BYTES_RST = 7'd64;

   // ASCII control codes.
   localparam logic [BYTE_W-1:0] CODE_STX  = 8'h02;
   localparam logic [BYTE_W-1:0] CODE_ETX  = 8'h03;
   localparam logic [BYTE_W-1:0] CODE_EOT  = 8'h04;
   localparam logic [BYTE_W-1:0] CODE_ENQ  = 8'h05;
   localparam logic [BYTE_W-1:0] CODE_ACK  = 8'h06;
   localparam logic [BYTE_W-1:0] CODE_NAK  = 8'h15;
   localparam logic [BYTE_W-1:0] BCC_FLOOR = 8'h20;

   typedef struct packed {
      logic              data_valid;
      logic [BYTE_W-1:0] data_byte;
      logic              frame_done;
      status_type        status;
      logic [CNT_W-1:0]  frame_length;
   } result_type;

endpackage

/* rtl/stx_etx_bcc_frame_receiver.sv */
// ----------------------------------------------------------------------------
// stx_etx_bcc_frame_receiver
// Receives one STX/ETX reply frame byte by byte and checks its XOR BCC.
// ----------------------------------------------------------------------------
// A start item arms the receiver; each byte item is forwarded as one result
// item, and each interval item counts one retry. The frame ends on a good or
// bad BCC (the byte after an ETX at index 1 or later), on ACK, NAK or ENQ,
// on EOT at index 2 or later, or when the byte count or the retry count
// reaches max_bytes (0 acts as 1, values above FRAME_MAX act as FRAME_MAX).
// The frame state and the result register are updated in the cycle the item
// is accepted, so one item can be accepted in every cycle unless the result
// channel stalls. The result register sits between the two channels, and a
// new item is taken whenever that register is empty or is being drained in
// the same cycle. Start items, interval items below the limit, items while
// idle and the unused action code give no result item.
`include "assert_macros.svh"

module stx_etx_bcc_frame_receiver
   import sebfr_pkg::*;
#(
   parameter int FRAME_MAX = FRAME_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] action
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [14:8] frame_length, [15] zero
   output logic [2:0]  rsp_tuser,   // [0] data_valid, [2:1] status
   output logic        rsp_tlast,   // frame_done
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Frame state.
   logic              receiving_ff, receiving_in;
   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [CNT_W-1:0]  retry_count_ff, retry_count_in;
   logic              seen_stx_ff, seen_stx_in;
   logic [BYTE_W-1:0] xor_sum_ff, xor_sum_in;
   logic              last_etx_ff, last_etx_in;
   logic [CNT_W-1:0]  max_bytes_ff, max_bytes_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   logic              req_accept;
   action_type        action;
   logic [BYTE_W-1:0] rx_byte;
   logic [CNT_W-1:0]  limit;
   logic [CNT_W-1:0]  byte_count_inc;
   logic [CNT_W-1:0]  retry_count_inc;
   logic [BYTE_W-1:0] bcc_expect;
   logic              ends_frame;
   logic              produce;
   logic              csr_write;

   assign action  = action_type'(req_tuser);
   assign rx_byte = req_tdata;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_BYTES) ? {25'd0, max_bytes_ff} : 32'd0;

   always_comb begin
      max_bytes_in = max_bytes_ff;
      if (csr_write && csr_paddr[2] == REG_MAX_BYTES) begin
         max_bytes_in = csr_pwdata[CNT_W-1:0];
      end
   end

   // Effective limit after clamping to the range 1 .. FRAME_MAX.
   always_comb begin
      limit = max_bytes_ff;
      if (max_bytes_ff == '0) begin
         limit = CNT_W'(1);
      end else if (int'(max_bytes_ff) > FRAME_MAX) begin
         limit = CNT_W'(FRAME_MAX);
      end
   end

   assign byte_count_inc  = byte_count_ff + CNT_W'(1);
   assign retry_count_inc = retry_count_ff + CNT_W'(1);

   // The checksum is lifted above the control range when it falls below it.
   assign bcc_expect = (xor_sum_ff < BCC_FLOOR) ? (xor_sum_ff + BCC_FLOOR) : xor_sum_ff;

   assign ends_frame = (rx_byte == CODE_ACK) || (rx_byte == CODE_NAK) ||
                       (rx_byte == CODE_ENQ) ||
                       ((byte_count_ff >= CNT_W'(2)) && (rx_byte == CODE_EOT));

   always_comb begin
      receiving_in   = receiving_ff;
      byte_count_in  = byte_count_ff;
      retry_count_in = retry_count_ff;
      seen_stx_in    = seen_stx_ff;
      xor_sum_in     = xor_sum_ff;
      last_etx_in    = last_etx_ff;
      produce        = 1'b0;
      rsp_in         = rsp_ff;

      if (req_accept) begin
         case (action)
            ACT_START: begin
               receiving_in   = 1'b1;
               byte_count_in  = '0;
               retry_count_in = '0;
               seen_stx_in    = 1'b0;
               xor_sum_in     = '0;
               last_etx_in    = 1'b0;
            end
            ACT_TICK: begin
               if (receiving_ff) begin
                  retry_count_in = retry_count_inc;
                  if (retry_count_inc >= limit) begin
                     receiving_in        = 1'b0;
                     produce             = 1'b1;
                     rsp_in.data_valid   = 1'b0;
                     rsp_in.data_byte    = '0;
                     rsp_in.frame_done   = 1'b1;
                     rsp_in.frame_length = byte_count_ff;
                     rsp_in.status       = (byte_count_ff != '0) ? ST_LIMIT : ST_TIMEOUT;
                  end
               end
            end
            ACT_BYTE: begin
               if (receiving_ff) begin
                  produce          = 1'b1;
                  rsp_in.data_byte = rx_byte;
                  if (last_etx_ff) begin
                     // This byte is the BCC; a frame without STX always passes.
                     receiving_in        = 1'b0;
                     rsp_in.data_valid   = 1'b0;
                     rsp_in.frame_done   = 1'b1;
                     rsp_in.frame_length = byte_count_ff;
                     rsp_in.status = (!seen_stx_ff || bcc_expect == rx_byte) ?
                                     ST_OK : ST_CHKSUM;
                  end else begin
                     if (seen_stx_ff) begin
                        xor_sum_in = xor_sum_ff ^ rx_byte;
                     end else if (rx_byte == CODE_STX) begin
                        seen_stx_in = 1'b1;
                     end
                     last_etx_in         = (rx_byte == CODE_ETX) && (byte_count_ff != '0);
                     byte_count_in       = byte_count_inc;
                     rsp_in.data_valid   = 1'b1;
                     rsp_in.frame_length = byte_count_inc;
                     if (ends_frame) begin
                        receiving_in      = 1'b0;
                        rsp_in.frame_done = 1'b1;
                        rsp_in.status     = ST_OK;
                     end else if (byte_count_inc >= limit) begin
                        receiving_in      = 1'b0;
                        rsp_in.frame_done = 1'b1;
                        rsp_in.status     = ST_LIMIT;
                     end else begin
                        rsp_in.frame_done = 1'b0;
                        rsp_in.status     = ST_OK;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff   <= 1'b0;
         byte_count_ff  <= '0;
         retry_count_ff <= '0;
         seen_stx_ff    <= 1'b0;
         xor_sum_ff     <= '0;
         last_etx_ff    <= 1'b0;
         max_bytes_ff   <= MAX_BYTES_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         receiving_ff   <= receiving_in;
         byte_count_ff  <= byte_count_in;
         retry_count_ff <= retry_count_in;
         seen_stx_ff    <= seen_stx_in;
         xor_sum_ff     <= xor_sum_in;
         last_etx_ff    <= last_etx_in;
         max_bytes_ff   <= max_bytes_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.frame_length, rsp_ff.data_byte};
   assign rsp_tuser  = {rsp_ff.status, rsp_ff.data_valid};
   assign rsp_tlast  = rsp_ff.frame_done;

   // A result item that does not end the frame is always a kept byte.
   `ASSERT_IMPL(a_mid_frame_kept, clock, reset, rsp_valid_ff && !rsp_ff.frame_done, rsp_ff.data_valid && rsp_ff.status == ST_OK, "mid-frame result not a kept byte")

   // An item taken while idle leaves the result register empty.
   `ASSERT_NEXT(a_idle_silent, clock, reset, req_accept && !receiving_ff && action != ACT_START, !rsp_valid_ff, "result produced while idle")

   // A timeout reports an empty frame.
   `ASSERT_IMPL(a_timeout_empty, clock, reset, rsp_valid_ff && rsp_ff.status == ST_TIMEOUT, rsp_ff.frame_length == '0 && !rsp_ff.data_valid, "timeout with data")

endmodule
